// ----- rtl/core/frs_pkg.sv -----
// ----------------------------------------------------------------------------
// Floppy request sequencer package
// Shared types, constants and the diskette format table.
// ----------------------------------------------------------------------------
`default_nettype none

package frs_pkg;

   localparam int ErrorLimit = 8;
   localparam int BlockBits  = 12;

   localparam logic [7:0] OP_SPECIFY = 8'h03;
   localparam logic [7:0] OP_RECAL   = 8'h07;
   localparam logic [7:0] OP_SEEK    = 8'h0F;
   localparam logic [7:0] OP_READ    = 8'hE6;
   localparam logic [7:0] OP_WRITE   = 8'hC5;

   localparam logic [8:0] NO_SPEC = 9'h1FF;
   localparam logic [2:0] NO_RATE = 3'd7;

   typedef enum logic [2:0] {
      KIND_CMD   = 3'd0,
      KIND_OK    = 3'd1,
      KIND_FAIL  = 3'd2,
      KIND_RESET = 3'd3,
      KIND_RATE  = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_RESET = 3'd1,
      PH_RECAL = 3'd2,
      PH_SEEK  = 3'd3,
      PH_RW    = 3'd4
   } phase_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_DIVIDE,
      ST_DIVWAIT,
      ST_PLAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [12:0] size;
      logic [4:0]  sect;
      logic        stretch;
      logic [7:0]  gap;
      logic [2:0]  rate;
      logic [7:0]  spec;
   } fmt_type;

   function automatic fmt_type fmt_lookup(input logic [2:0] idx);
      fmt_type f;
      unique case (idx)
         3'd1:    f = '{13'd720,  5'd9,  1'b0, 8'h2A, 3'd2, 8'hDF};
         3'd2:    f = '{13'd2400, 5'd15, 1'b0, 8'h1B, 3'd0, 8'hDF};
         3'd3:    f = '{13'd720,  5'd9,  1'b1, 8'h2A, 3'd2, 8'hDF};
         3'd4:    f = '{13'd1440, 5'd9,  1'b0, 8'h2A, 3'd2, 8'hDF};
         3'd5:    f = '{13'd720,  5'd9,  1'b1, 8'h23, 3'd1, 8'hDF};
         3'd6:    f = '{13'd1440, 5'd9,  1'b0, 8'h23, 3'd1, 8'hDF};
         3'd7:    f = '{13'd2880, 5'd18, 1'b0, 8'h1B, 3'd0, 8'hCF};
         default: f = '{13'd0,    5'd0,  1'b0, 8'h00, 3'd0, 8'h00};
      endcase
      return f;
   endfunction

   // Datapath commands from the controller.
   typedef struct packed {
      logic div_start;
   } frs_cmd_type;

   typedef struct packed {
      logic div_done;
   } frs_status_type;

endpackage

`default_nettype wire

// ----- rtl/core/frs_divider.sv -----
// ----------------------------------------------------------------------------
// Block split datapath
// Restoring divider that splits a block into sector, head and track.
// ----------------------------------------------------------------------------
`default_nettype none

module frs_divider (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire frs_pkg::frs_cmd_type         cmd,
   input  wire logic [frs_pkg::BlockBits-1:0] block,
   input  wire logic [4:0]                   sect,
   output frs_pkg::frs_status_type           status,
   output logic [7:0]                        sector,
   output logic                              head,
   output logic [7:0]                        track
);
   import frs_pkg::*;

   logic [BlockBits-1:0] quot_ff, quot_in;
   logic [4:0]  rem_ff, rem_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quot_ff[BlockBits-1]};
      if (cmd.div_start) begin
         quot_in = block;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, sect}) begin
            rem_in  = 5'(trial - {1'b0, sect});
            quot_in = {quot_ff[BlockBits-2:0], 1'b1};
         end else begin
            rem_in  = trial[4:0];
            quot_in = {quot_ff[BlockBits-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'(BlockBits - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
   end

   assign status.div_done = done_ff;
   assign sector = {3'd0, rem_ff} + 8'd1;
   assign head   = quot_ff[0];
   assign track  = quot_ff[8:1];

endmodule

`default_nettype wire

// ----- rtl/core/frs_control.sv -----
// ----------------------------------------------------------------------------
// Request sequencer controller
// Holds the request state and emits controller bytes one word at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module frs_control (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic                   act,
   input  wire logic [1:0]             drive,
   input  wire logic [2:0]             format_type,
   input  wire logic [11:0]            block_in,
   input  wire logic                   is_write,
   input  wire logic [2:0]             reply_count,
   input  wire logic [7:0]             status0,
   input  wire logic [7:0]             status1,
   input  wire logic [7:0]             status2,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [2:0]                  rsp_kind,
   output logic [7:0]                  rsp_value,
   output logic                        rsp_last,
   output frs_pkg::frs_cmd_type        cmd,
   input  wire frs_pkg::frs_status_type status,
   output logic [frs_pkg::BlockBits-1:0] div_block,
   output logic [4:0]                  div_sect,
   input  wire logic [7:0]             div_sector,
   input  wire logic                   div_head,
   input  wire logic [7:0]             div_track
);
   import frs_pkg::*;

   state_type  state_ff, state_in;
   phase_type  phase_ff, phase_in;
   logic       rstp_ff, rstp_in, recp_ff, recp_in;
   logic [1:0] adrv_ff, adrv_in;
   logic [7:0] ptrk_ff, ptrk_in, ttrk_ff, ttrk_in;
   logic [3:0] err_ff, err_in;
   logic [8:0] spec_ff, spec_in;
   logic [2:0] rate_ff, rate_in;
   logic       pv_ff, pv_in, pw_ff, pw_in;
   logic [1:0] pd_ff, pd_in;
   logic [2:0] pf_ff, pf_in;
   logic [BlockBits-1:0] pb_ff, pb_in;
   logic [7:0] sec_ff, sec_in, trk_ff, trk_in;
   logic       hd_ff, hd_in, cw_ff, cw_in, seek_ff, seek_in;
   // Result queue: up to 13 words built per item, drained in order.
   logic [10:0] q_ff [16];
   logic [10:0] q_in [16];
   logic [3:0] qn_ff, qn_in, qr_ff, qr_in;
   logic       oval_ff, oval_in;
   logic [11:0] out_ff, out_in;
   logic [4:0] n;
   fmt_type    f;
   logic [7:0] tt;
   logic [4:0] ne;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_IDLE;
         rstp_ff  <= 1'b0;
         recp_ff  <= 1'b0;
         adrv_ff  <= '0;
         ptrk_ff  <= 8'd255;
         ttrk_ff  <= '0;
         err_ff   <= '0;
         spec_ff  <= NO_SPEC;
         rate_ff  <= NO_RATE;
         pv_ff    <= 1'b0;
         sec_ff   <= '0;
         trk_ff   <= '0;
         hd_ff    <= 1'b0;
         cw_ff    <= 1'b0;
         qn_ff    <= '0;
         qr_ff    <= '0;
         oval_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         rstp_ff  <= rstp_in;
         recp_ff  <= recp_in;
         adrv_ff  <= adrv_in;
         ptrk_ff  <= ptrk_in;
         ttrk_ff  <= ttrk_in;
         err_ff   <= err_in;
         spec_ff  <= spec_in;
         rate_ff  <= rate_in;
         pv_ff    <= pv_in;
         sec_ff   <= sec_in;
         trk_ff   <= trk_in;
         hd_ff    <= hd_in;
         cw_ff    <= cw_in;
         qn_ff    <= qn_in;
         qr_ff    <= qr_in;
         oval_ff  <= oval_in;
      end
      pw_ff   <= pw_in;
      pd_ff   <= pd_in;
      pf_ff   <= pf_in;
      pb_ff   <= pb_in;
      seek_ff <= seek_in;
      out_ff  <= out_in;
      q_ff    <= q_in;
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      rstp_in  = rstp_ff;
      recp_in  = recp_ff;
      adrv_in  = adrv_ff;
      ptrk_in  = ptrk_ff;
      ttrk_in  = ttrk_ff;
      err_in   = err_ff;
      spec_in  = spec_ff;
      rate_in  = rate_ff;
      pv_in    = pv_ff;
      pw_in    = pw_ff;
      pd_in    = pd_ff;
      pf_in    = pf_ff;
      pb_in    = pb_ff;
      sec_in   = sec_ff;
      trk_in   = trk_ff;
      hd_in    = hd_ff;
      cw_in    = cw_ff;
      seek_in  = seek_ff;
      q_in     = q_ff;
      qn_in    = qn_ff;
      qr_in    = qr_ff;
      oval_in  = oval_ff;
      out_in   = out_ff;
      cmd.div_start = 1'b0;
      req_tready = 1'b0;
      n  = {1'b0, qn_ff};
      f  = fmt_lookup(pf_ff);
      tt = f.stretch ? {div_track[6:0], 1'b0} : div_track;
      ne = '0;

      if (oval_ff && rsp_tready) begin
         oval_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               n = '0;
               qr_in = '0;
               if (!act) begin
                  if (phase_ff == PH_IDLE && !pv_ff) begin
                     pv_in = 1'b1;
                     pw_in = is_write;
                     pd_in = drive;
                     pf_in = format_type;
                     pb_in = BlockBits'(block_in);
                     err_in = '0;
                     state_in = ST_DISPATCH;
                  end
               end else begin
                  unique case (phase_ff)
                     PH_RW: begin
                        if (reply_count != 3'd7 || (status0 & 8'hF8) != 0 ||
                            (status1 & 8'hBF) != 0 || (status2 & 8'h73) != 0) begin
                           if (status1[1]) begin
                              q_in[n[3:0]] = {KIND_FAIL, 8'd0}; n = n + 5'd1;
                              pv_in = 1'b0;
                           end else begin
                              if (pv_ff && err_ff >= 4'(ErrorLimit)) begin
                                 q_in[n[3:0]] = {KIND_FAIL, 8'd0}; n = n + 5'd1;
                                 pv_in = 1'b0;
                              end
                              ne = {1'b0, err_ff} + 5'd1;
                              err_in = (ne > 5'd15) ? 4'd15 : ne[3:0];
                              if (ne > 5'(ErrorLimit / 2)) rstp_in = 1'b1;
                              else recp_in = 1'b1;
                           end
                        end else begin
                           q_in[n[3:0]] = {KIND_OK, 8'd0}; n = n + 5'd1;
                           pv_in = 1'b0;
                        end
                        state_in = ST_DISPATCH;
                     end
                     PH_SEEK: begin
                        if (reply_count != 3'd2 || (status0 & 8'hF8) != 8'h20 ||
                            status1 != ttrk_ff) begin
                           if (pv_ff && err_ff >= 4'(ErrorLimit)) begin
                              q_in[n[3:0]] = {KIND_FAIL, 8'd0}; n = n + 5'd1;
                              pv_in = 1'b0;
                           end
                           ne = {1'b0, err_ff} + 5'd1;
                           err_in = (ne > 5'd15) ? 4'd15 : ne[3:0];
                           if (ne > 5'(ErrorLimit / 2)) rstp_in = 1'b1;
                           else recp_in = 1'b1;
                           state_in = ST_DISPATCH;
                        end else begin
                           ptrk_in = status1;
                           q_in[0] = {KIND_CMD, cw_ff ? OP_WRITE : OP_READ};
                           q_in[1] = {KIND_CMD, 5'd0, hd_ff, adrv_ff};
                           q_in[2] = {KIND_CMD, trk_ff};
                           q_in[3] = {KIND_CMD, 7'd0, hd_ff};
                           q_in[4] = {KIND_CMD, sec_ff};
                           q_in[5] = {KIND_CMD, 8'd2};
                           q_in[6] = {KIND_CMD, 3'd0, f.sect};
                           q_in[7] = {KIND_CMD, f.gap};
                           q_in[8] = {KIND_CMD, 8'hFF};
                           n = 5'd9;
                           phase_in = PH_RW;
                           state_in = ST_EMIT;
                        end
                     end
                     PH_RECAL: begin
                        if (reply_count != 3'd2 || (status0 & 8'hE0) == 8'h60)
                           rstp_in = 1'b1;
                        else
                           recp_in = 1'b0;
                        state_in = ST_DISPATCH;
                     end
                     PH_RESET: begin
                        q_in[0] = {KIND_CMD, OP_SPECIFY};
                        q_in[1] = {KIND_CMD, spec_ff[7:0]};
                        q_in[2] = {KIND_CMD, 8'd6};
                        n = 5'd3;
                        state_in = ST_DISPATCH;
                     end
                     default: begin
                        if (reply_count != 3'd2 || (status0 & 8'hE0) == 8'h60)
                           rstp_in = 1'b1;
                        else
                           recp_in = 1'b1;
                     end
                  endcase
               end
               qn_in = n[3:0];
            end
         end
         ST_DISPATCH: begin
            if (rstp_ff) begin
               rstp_in = 1'b0;
               spec_in = NO_SPEC;
               rate_in = NO_RATE;
               recp_in = 1'b1;
               q_in[n[3:0]] = {KIND_RESET, 8'd0}; n = n + 5'd1;
               phase_in = PH_RESET;
               state_in = ST_EMIT;
            end else if (recp_ff) begin
               recp_in = 1'b0;
               ptrk_in = '0;
               q_in[n[3:0]] = {KIND_CMD, OP_RECAL}; n = n + 5'd1;
               q_in[n[3:0]] = {KIND_CMD, 5'd0, hd_ff, adrv_ff}; n = n + 5'd1;
               phase_in = PH_RECAL;
               state_in = ST_EMIT;
            end else if (!pv_ff) begin
               phase_in = PH_IDLE;
               state_in = ST_EMIT;
            end else begin
               seek_in = (pd_ff != adrv_ff);
               adrv_in = pd_ff;
               if (({1'b0, pb_ff} + (BlockBits + 1)'(2)) > (BlockBits + 1)'(f.size) ||
                   f.sect == 5'd0) begin
                  q_in[n[3:0]] = {KIND_FAIL, 8'd0}; n = n + 5'd1;
                  pv_in = 1'b0;
               end else begin
                  state_in = ST_DIVIDE;
               end
            end
            qn_in = n[3:0];
         end
         ST_DIVIDE: begin
            cmd.div_start = 1'b1;
            state_in = ST_DIVWAIT;
         end
         ST_DIVWAIT: begin
            if (status.div_done) state_in = ST_PLAN;
         end
         ST_PLAN: begin
            cw_in  = pw_ff;
            sec_in = div_sector;
            hd_in  = div_head;
            trk_in = div_track;
            ttrk_in = tt;
            if (tt != ptrk_ff) seek_in = 1'b1;
            if (spec_ff != {1'b0, f.spec}) begin
               spec_in = {1'b0, f.spec};
               q_in[n[3:0]] = {KIND_CMD, OP_SPECIFY}; n = n + 5'd1;
               q_in[n[3:0]] = {KIND_CMD, f.spec}; n = n + 5'd1;
               q_in[n[3:0]] = {KIND_CMD, 8'd6}; n = n + 5'd1;
            end
            if (rate_ff != f.rate) begin
               rate_in = f.rate;
               q_in[n[3:0]] = {KIND_RATE, 5'd0, f.rate}; n = n + 5'd1;
            end
            if (!(seek_ff || tt != ptrk_ff)) begin
               q_in[n[3:0]] = {KIND_CMD, pw_ff ? OP_WRITE : OP_READ}; n = n + 5'd1;
               q_in[n[3:0]] = {KIND_CMD, 5'd0, div_head, adrv_ff}; n = n + 5'd1;
               q_in[n[3:0]] = {KIND_CMD, div_track}; n = n + 5'd1;
               q_in[n[3:0]] = {KIND_CMD, 7'd0, div_head}; n = n + 5'd1;
               q_in[n[3:0]] = {KIND_CMD, div_sector}; n = n + 5'd1;
               q_in[n[3:0]] = {KIND_CMD, 8'd2}; n = n + 5'd1;
               q_in[n[3:0]] = {KIND_CMD, 3'd0, f.sect}; n = n + 5'd1;
               q_in[n[3:0]] = {KIND_CMD, f.gap}; n = n + 5'd1;
               q_in[n[3:0]] = {KIND_CMD, 8'hFF}; n = n + 5'd1;
               phase_in = PH_RW;
            end else begin
               q_in[n[3:0]] = {KIND_CMD, (tt != 8'd0) ? OP_SEEK : OP_RECAL};
               n = n + 5'd1;
               q_in[n[3:0]] = {KIND_CMD, 5'd0, div_head, adrv_ff}; n = n + 5'd1;
               if (tt != 8'd0) begin
                  q_in[n[3:0]] = {KIND_CMD, tt}; n = n + 5'd1;
               end
               phase_in = PH_SEEK;
            end
            qn_in = n[3:0];
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (qr_ff == qn_ff) begin
               state_in = ST_IDLE;
            end else if (!oval_ff || rsp_tready) begin
               oval_in = 1'b1;
               out_in  = {(qr_ff + 4'd1) == qn_ff, q_ff[qr_ff]};
               qr_in   = qr_ff + 4'd1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tvalid = oval_ff;
   assign rsp_kind   = out_ff[10:8];
   assign rsp_value  = out_ff[7:0];
   assign rsp_last   = out_ff[11];
   assign div_block  = pb_ff;
   assign div_sect   = f.sect;

endmodule

`default_nettype wire

// ----- rtl/core/floppy_request_sequencer.sv -----
// ----------------------------------------------------------------------------
// Floppy request sequencer
// Turns block requests and controller replies into command and result words.
// ----------------------------------------------------------------------------
// Channel  Direction  Contents
// req      in         tuser: action; tdata: request fields and reply bytes
// rsp      out        tuser: kind; tdata: command byte or rate; tlast: final word
//
// A new block request waits on the 12-step block divider after dispatch, and
// planning then queues its result words, which drain one per cycle while the
// result port is ready; replies that lead to a pending request use it too.
// Reset is synchronous and clears the sequencing state but not the pending
// request fields, seek flag or queue contents. A stalled result port holds
// the drain; the next request is taken once the last result word is registered.
`default_nettype none

module floppy_request_sequencer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // action
   input  wire logic        req_tuser,
   // drive, format_type, block, is_write, reply_count, status0, status1, status2
   input  wire logic [47:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // kind
   output logic [2:0]       rsp_tuser,
   // value
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tlast
);
   import frs_pkg::*;

   frs_cmd_type    cmd;
   frs_status_type status;
   logic [BlockBits-1:0] div_block;
   logic [4:0]     div_sect;
   logic [7:0]     div_sector, div_track;
   logic           div_head;

   frs_divider u_div (
      .clock(clock), .reset(reset), .cmd(cmd), .block(div_block),
      .sect(div_sect), .status(status), .sector(div_sector),
      .head(div_head), .track(div_track)
   );

   frs_control u_ctl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .act(req_tuser), .drive(req_tdata[1:0]), .format_type(req_tdata[4:2]),
      .block_in(req_tdata[16:5]), .is_write(req_tdata[17]),
      .reply_count(req_tdata[20:18]), .status0(req_tdata[28:21]),
      .status1(req_tdata[36:29]), .status2(req_tdata[44:37]),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_kind(rsp_tuser), .rsp_value(rsp_tdata), .rsp_last(rsp_tlast),
      .cmd(cmd), .status(status), .div_block(div_block), .div_sect(div_sect),
      .div_sector(div_sector), .div_head(div_head), .div_track(div_track)
   );

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// Floppy request sequencer testbench
// Sends block requests and controller replies, predicts the result words from a
// behavioral copy of the sequencer or the directed row, and checks them in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   import frs_pkg::*;

   localparam int ItemCount  = 405;
   localparam int CycleLimit = 1500000;
   localparam int DrainWait  = 80;

   typedef struct {
      logic       action;
      logic [1:0] drive;
      logic [2:0] fmt;
      logic [11:0] blk;
      logic       wr;
      logic [2:0] cnt;
      logic [7:0] s0;
      logic [7:0] s1;
      logic [7:0] s2;
   } req_item_type;

   typedef struct {
      kind_type   kind;
      logic [7:0] value;
      logic       last;
   } rsp_word_type;

   typedef struct {
      req_item_type item;
      bit         typed;
      int         n_words;
      kind_type   kind;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic        req_tuser;
   logic [47:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [2:0]  rsp_tuser;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;

   floppy_request_sequencer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // Diskette formats: size, sectors per track, stretch, gap, rate, specify byte.
   int unsigned fmt_size[8]    = '{0, 720, 2400, 720, 1440, 720, 1440, 2880};
   int unsigned fmt_sect[8]    = '{0, 9, 15, 9, 9, 9, 9, 18};
   int unsigned fmt_stretch[8] = '{0, 0, 0, 1, 0, 1, 0, 0};
   logic [7:0]  fmt_gap[8]     = '{8'h00, 8'h2A, 8'h1B, 8'h2A, 8'h2A, 8'h23, 8'h23, 8'h1B};
   logic [2:0]  fmt_rate[8]    = '{3'd0, 3'd2, 3'd0, 3'd2, 3'd2, 3'd1, 3'd1, 3'd0};
   logic [8:0]  fmt_spec[8]    = '{9'h00, 9'hDF, 9'hDF, 9'hDF, 9'hDF, 9'hDF, 9'hDF, 9'hCF};

   phase_type   m_phase;
   bit          m_reset_pend, m_recal_pend;
   logic [1:0]  m_drive;
   logic [7:0]  m_present, m_target;
   int unsigned m_errors;
   logic [8:0]  m_spec;
   logic [2:0]  m_rate;
   bit          m_pend_valid, m_pend_wr;
   logic [1:0]  m_pend_drive;
   logic [2:0]  m_pend_fmt;
   logic [11:0] m_pend_blk;
   logic [7:0]  m_sector, m_track;
   logic        m_head, m_wr;

   rsp_word_type step_words[$];
   rsp_word_type expected_words[$];
   bit          failed = 1'b0;
   int          cycles = 0;
   bit          hostile;
   bit          calm;

   task automatic put_word(input kind_type k, input logic [7:0] v);
      rsp_word_type w;
      w.kind  = k;
      w.value = v;
      w.last  = 1'b0;
      step_words.push_back(w);
   endtask

   task automatic send_rw_words();
      put_word(KIND_CMD, m_wr ? OP_WRITE : OP_READ);
      put_word(KIND_CMD, {5'd0, m_head, m_drive});
      put_word(KIND_CMD, m_track);
      put_word(KIND_CMD, {7'd0, m_head});
      put_word(KIND_CMD, m_sector);
      put_word(KIND_CMD, 8'd2);
      put_word(KIND_CMD, 8'(fmt_sect[m_pend_fmt]));
      put_word(KIND_CMD, fmt_gap[m_pend_fmt]);
      put_word(KIND_CMD, 8'hFF);
      m_phase = PH_RW;
   endtask

   task automatic plan_next();
      bit          do_seek;
      int unsigned q;
      forever begin
         if (m_reset_pend) begin
            m_reset_pend = 0;
            m_spec       = NO_SPEC;
            m_rate       = NO_RATE;
            m_recal_pend = 1;
            put_word(KIND_RESET, 8'd0);
            m_phase = PH_RESET;
            return;
         end
         if (m_recal_pend) begin
            m_recal_pend = 0;
            m_present    = 8'd0;
            put_word(KIND_CMD, OP_RECAL);
            put_word(KIND_CMD, {5'd0, m_head, m_drive});
            m_phase = PH_RECAL;
            return;
         end
         if (!m_pend_valid) begin
            m_phase = PH_IDLE;
            return;
         end
         do_seek = (m_pend_drive != m_drive);
         m_drive = m_pend_drive;
         if (m_pend_blk + 2 > fmt_size[m_pend_fmt] || fmt_sect[m_pend_fmt] == 0) begin
            put_word(KIND_FAIL, 8'd0);
            m_pend_valid = 0;
            continue;
         end
         m_wr     = m_pend_wr;
         m_sector = 8'(m_pend_blk % fmt_sect[m_pend_fmt] + 1);
         q        = m_pend_blk / fmt_sect[m_pend_fmt];
         m_head   = 1'(q % 2);
         m_track  = 8'(q / 2);
         m_target = m_track << fmt_stretch[m_pend_fmt];
         if (m_target != m_present) do_seek = 1;
         if (m_spec != fmt_spec[m_pend_fmt]) begin
            m_spec = fmt_spec[m_pend_fmt];
            put_word(KIND_CMD, OP_SPECIFY);
            put_word(KIND_CMD, m_spec[7:0]);
            put_word(KIND_CMD, 8'd6);
         end
         if (m_rate != fmt_rate[m_pend_fmt]) begin
            m_rate = fmt_rate[m_pend_fmt];
            put_word(KIND_RATE, {5'd0, m_rate});
         end
         if (!do_seek) begin
            send_rw_words();
         end else if (m_target != 0) begin
            put_word(KIND_CMD, OP_SEEK);
            put_word(KIND_CMD, {5'd0, m_head, m_drive});
            put_word(KIND_CMD, m_target);
            m_phase = PH_SEEK;
         end else begin
            put_word(KIND_CMD, OP_RECAL);
            put_word(KIND_CMD, {5'd0, m_head, m_drive});
            m_phase = PH_SEEK;
         end
         return;
      end
   endtask

   task automatic count_error();
      int unsigned n;
      n = m_errors + 1;
      if (m_pend_valid && m_errors >= ErrorLimit) begin
         put_word(KIND_FAIL, 8'd0);
         m_pend_valid = 0;
      end
      m_errors = (n > 15) ? 15 : n;
      if (n > ErrorLimit / 2) m_reset_pend = 1;
      else m_recal_pend = 1;
   endtask

   task automatic sequencer_step(input req_item_type it);
      step_words.delete();
      if (!it.action) begin
         if (m_phase == PH_IDLE && !m_pend_valid) begin
            m_pend_valid = 1;
            m_pend_wr    = it.wr;
            m_pend_drive = it.drive;
            m_pend_fmt   = it.fmt;
            m_pend_blk   = it.blk;
            m_errors     = 0;
            plan_next();
         end
      end else begin
         case (m_phase)
            PH_RW: begin
               if (it.cnt != 7 || (it.s0 & 8'hF8) || (it.s1 & 8'hBF) || (it.s2 & 8'h73)) begin
                  if (it.s1[1]) begin
                     put_word(KIND_FAIL, 8'd0);
                     m_pend_valid = 0;
                  end else begin
                     count_error();
                  end
               end else begin
                  put_word(KIND_OK, 8'd0);
                  m_pend_valid = 0;
               end
               plan_next();
            end
            PH_SEEK: begin
               if (it.cnt != 2 || (it.s0 & 8'hF8) != 8'h20 || it.s1 != m_target) begin
                  count_error();
                  plan_next();
               end else begin
                  m_present = it.s1;
                  send_rw_words();
               end
            end
            PH_RECAL: begin
               if (it.cnt != 2 || (it.s0 & 8'hE0) == 8'h60) m_reset_pend = 1;
               else m_recal_pend = 0;
               plan_next();
            end
            PH_RESET: begin
               put_word(KIND_CMD, OP_SPECIFY);
               put_word(KIND_CMD, m_spec[7:0]);
               put_word(KIND_CMD, 8'd6);
               plan_next();
            end
            default: begin
               if (it.cnt != 2 || (it.s0 & 8'hE0) == 8'h60) m_reset_pend = 1;
               else m_recal_pend = 1;
            end
         endcase
      end
      if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
   endtask

   function automatic logic [47:0] pack_item(input req_item_type it);
      return {3'd0, it.s2, it.s1, it.s0, it.cnt, it.wr, it.blk, it.fmt, it.drive};
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic req_item_type make_request();
      req_item_type it;
      it        = '{default: '0};
      it.drive  = 2'($urandom_range(0, 3));
      it.wr     = 1'($urandom_range(0, 1));
      it.fmt    = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                              : 3'($urandom_range(1, 7));
      if (fmt_size[it.fmt] == 0 || $urandom_range(0, 6) == 0) it.blk = 12'($urandom);
      else it.blk = 12'($urandom_range(0, fmt_size[it.fmt] - 1));
      return it;
   endfunction

   function automatic req_item_type make_reply();
      req_item_type it;
      it        = '{default: '0};
      it.action = 1'b1;
      it.drive  = 2'($urandom);
      it.fmt    = 3'($urandom);
      it.blk    = 12'($urandom);
      it.wr     = 1'($urandom);
      if ($urandom_range(0, 99) < (hostile ? 60 : 12)) begin
         it.cnt = 3'($urandom);
         it.s0  = 8'($urandom);
         it.s1  = ($urandom_range(0, 3) == 0) ? m_target : 8'($urandom);
         it.s2  = 8'($urandom);
         return it;
      end
      case (m_phase)
         PH_SEEK: begin
            it.cnt = 3'd2;
            it.s0  = 8'h20 | 8'($urandom_range(0, 7));
            it.s1  = m_target;
            it.s2  = 8'($urandom);
         end
         PH_RW: begin
            it.cnt = 3'd7;
            it.s0  = 8'($urandom_range(0, 7));
            it.s1  = 8'($urandom) & 8'h40;
            it.s2  = 8'($urandom) & 8'h8C;
         end
         default: begin
            it.cnt = 3'd2;
            it.s0  = 8'($urandom);
            if ((it.s0 & 8'hE0) == 8'h60) it.s0[7] = 1'b1;
            it.s1  = 8'($urandom);
            it.s2  = 8'($urandom);
         end
      endcase
      return it;
   endfunction

   task automatic send_item(input req_item_type it, input bit typed, input int n_words,
                            input kind_type kind);
      int gap;
      rsp_word_type w;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.action;
      req_tdata  <= pack_item(it);
      do @(posedge clock); while (!req_tready);
      sequencer_step(it);
      if (typed) begin
         if (n_words == 1) begin
            w.kind  = kind;
            w.value = 8'd0;
            w.last  = 1'b1;
            expected_words.push_back(w);
         end
      end else begin
         foreach (step_words[i]) expected_words.push_back(step_words[i]);
      end
   endtask

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   int stall_left = 0;
   always @(posedge clock) begin
      rsp_word_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_words.size() == 0) begin
            $error("unexpected word: kind %0d value %0h", rsp_tuser, rsp_tdata);
            failed = 1;
         end else begin
            w = expected_words.pop_front();
            if (rsp_tuser !== w.kind) begin
               $error("kind: expected %0d, actual %0d", w.kind, rsp_tuser);
               failed = 1;
            end
            if (rsp_tdata !== w.value) begin
               $error("value: expected %0h, actual %0h", w.value, rsp_tdata);
               failed = 1;
            end
            if (rsp_tlast !== w.last) begin
               $error("last: expected %0b, actual %0b", w.last, rsp_tlast);
               failed = 1;
            end
         end
      end
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 25) begin
         stall_left <= ($urandom_range(0, 9) == 0) ? int'($urandom_range(10, 40))
                                                  : int'($urandom_range(0, 2));
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   stim_row_type rows[$];
   req_item_type it;
   int        sent;
   int        waited;

   function automatic stim_row_type row(input logic act, input int drv, input int fmt,
                                        input int blk, input logic wr, input int cnt,
                                        input int s0, input int s1, input int s2,
                                        input bit typed = 0, input int n_words = 0,
                                        input kind_type kind = KIND_CMD);
      stim_row_type r;
      r.item    = '{act, 2'(drv), 3'(fmt), 12'(blk), wr, 3'(cnt), 8'(s0), 8'(s1), 8'(s2)};
      r.typed   = typed;
      r.n_words = n_words;
      r.kind    = kind;
      return r;
   endfunction

   initial begin
      hostile    = 0;
      calm       = 0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = 1'b0;
      req_tdata  = '0;
      m_phase = PH_IDLE;  m_reset_pend = 0; m_recal_pend = 0; m_drive = 0;
      m_present = 8'hFF;  m_target = 0;     m_errors = 0;     m_spec = NO_SPEC;
      m_rate = NO_RATE;   m_pend_valid = 0; m_pend_wr = 0;    m_pend_drive = 0;
      m_pend_fmt = 0;     m_pend_blk = 0;   m_sector = 0;     m_track = 0;
      m_head = 0;         m_wr = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      rows.push_back(row(0, 0, 0, 0,    0, 0, 0,    0,    0,    1, 1, KIND_FAIL));
      rows.push_back(row(0, 3, 1, 719,  1, 0, 0,    0,    0,    1, 1, KIND_FAIL));
      rows.push_back(row(1, 0, 0, 0,    0, 2, 8'h00, 0,   0,    1, 0));
      rows.push_back(row(0, 0, 7, 0,    0, 0, 0,    0,    0));
      rows.push_back(row(1, 0, 0, 0,    0, 2, 8'h20, 0,   0));
      rows.push_back(row(1, 0, 0, 0,    0, 2, 8'h20, 0,   0));
      rows.push_back(row(1, 0, 0, 0,    0, 7, 0,    0,    0));
      rows.push_back(row(0, 3, 3, 717,  1, 0, 0,    0,    0));
      rows.push_back(row(1, 0, 0, 0,    0, 2, 8'h27, 8'h4E, 0));
      rows.push_back(row(1, 0, 0, 0,    0, 7, 8'h07, 8'h40, 8'h8C));
      rows.push_back(row(0, 1, 2, 4095, 0, 0, 0,    0,    0,    1, 1, KIND_FAIL));
      rows.push_back(row(0, 1, 5, 100,  1, 0, 0,    0,    0));
      rows.push_back(row(1, 0, 0, 0,    0, 1, 8'hFF, 8'hFF, 8'hFF));
      rows.push_back(row(1, 0, 0, 0,    0, 2, 8'h00, 0,   0));
      rows.push_back(row(1, 0, 0, 0,    0, 2, 8'h20, 8'h0A, 0));
      rows.push_back(row(1, 0, 0, 0,    0, 7, 8'h40, 8'h02, 0));
      rows.push_back(row(1, 2, 7, 4095, 1, 3, 8'h60, 8'hFF, 8'hFF, 1, 0));
      rows.push_back(row(0, 2, 6, 1437, 0, 0, 0,    0,    0));
      rows.push_back(row(1, 0, 0, 0,    0, 7, 0,    0,    0));
      rows.push_back(row(1, 0, 0, 0,    0, 2, 8'h60, 0,   0));
      rows.push_back(row(1, 0, 0, 0,    0, 0, 0,    0,    0));
      rows.push_back(row(1, 0, 0, 0,    0, 2, 8'h00, 0,   0));
      rows.push_back(row(1, 0, 0, 0,    0, 7, 8'h01, 8'h00, 8'h03));

      foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].n_words, rows[i].kind);

      sent = 0;
      while (sent < ItemCount) begin
         if (sent % 40 == 0) begin
            hostile = ($urandom_range(0, 3) == 0);
            calm    = ($urandom_range(0, 4) == 0);
         end
         if (sent == ItemCount / 2) begin
            req_tvalid <= 1'b0;
            while (expected_words.size() != 0) @(posedge clock);
         end
         if (m_phase == PH_IDLE && !m_pend_valid) it = make_request();
         else if ($urandom_range(0, 19) == 0) it = make_request();
         else it = make_reply();
         if ($urandom_range(0, 14) == 0) it = make_reply();
         send_item(it, 0, 0, KIND_CMD);
         if (it.action || m_pend_valid || step_words.size() > 0) sent++;
      end
      req_tvalid <= 1'b0;

      waited = 0;
      while (expected_words.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (DrainWait) @(posedge clock);
      if (!failed && expected_words.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire
